[hw/rtl/jtl_pkg.sv]
// Shared types, token codes and per-byte lexing function for the JSON token lexer.
// No dependencies.
package jtl_pkg;

    localparam int unsigned MaxTextLenDefault = 65535;

    localparam logic [4:0] KindNull  = 5'd0;
    localparam logic [4:0] KindStr   = 5'd1;
    localparam logic [4:0] KindTrue  = 5'd2;
    localparam logic [4:0] KindFalse = 5'd3;
    localparam logic [4:0] KindInt   = 5'd4;
    localparam logic [4:0] KindFloat = 5'd5;
    localparam logic [4:0] KindArrL  = 5'd6;
    localparam logic [4:0] KindArrR  = 5'd7;
    localparam logic [4:0] KindObjL  = 5'd8;
    localparam logic [4:0] KindObjR  = 5'd9;
    localparam logic [4:0] KindColon = 5'd10;
    localparam logic [4:0] KindComma = 5'd11;
    localparam logic [4:0] KindErr   = 5'd12;
    localparam logic [4:0] KindEof   = 5'd13;
    localparam logic [4:0] KindFmtD  = 5'd14;
    localparam logic [4:0] KindFmtF  = 5'd15;
    localparam logic [4:0] KindFmtB  = 5'd16;
    localparam logic [4:0] KindFmtS  = 5'd17;
    localparam logic [4:0] KindFmtJ  = 5'd18;

    typedef enum logic [3:0] {
        M_START, M_PCT, M_KW_N, M_KW_T, M_KW_F, M_MINUS, M_ZERO, M_INTD,
        M_DOT, M_FRACD, M_EXPE, M_EXPS, M_EXPD, M_STR, M_ESC, M_HEX
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [2:0]  kw;
        logic [15:0] tbeg;
        logic [15:0] vend;
        logic        flt;
        logic [15:0] suf;
        logic [1:0]  sufn;
    } t_lex_state;

    typedef struct packed {
        logic [15:0] len;
        logic [15:0] off;
        logic [4:0]  kind;
    } t_token;

    typedef struct packed {
        t_lex_state       st;
        logic [1:0]       n;
        t_token [2:0]     tok;
        logic             relex;
        logic             clr_pos;
    } t_feed;

    typedef struct packed {
        logic [2:0]   cnt;
        t_token [3:0] tok;
    } t_batch;

    localparam t_lex_state LexReset = '{mode: M_START, default: '0};

    function automatic logic is_dig(logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic [7:0] kw_char(t_mode m, logic [2:0] k);
        logic [7:0] c;
        c = 8'h00;
        case (m)
            M_KW_N:  c = (k == 3'd0) ? "u" : "l";
            M_KW_T:  c = (k == 3'd0) ? "r" : ((k == 3'd1) ? "u" : "e");
            default: begin
                case (k)
                    3'd0:    c = "a";
                    3'd1:    c = "l";
                    3'd2:    c = "s";
                    default: c = "e";
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic t_feed emit(t_feed f, logic [4:0] kind, logic [15:0] off,
                                   logic [15:0] len);
        t_feed g;
        g = f;
        if (g.n != 2'd3) begin
            g.tok[g.n] = '{len: len, off: off, kind: kind};
            g.n        = g.n + 2'd1;
        end
        return g;
    endfunction

    function automatic t_feed fail(t_feed f, logic [7:0] b);
        t_feed g;
        g             = emit(f, KindErr, '0, '0);
        g.st.mode     = M_START;
        g.st.kw       = '0;
        g.relex       = (b == 8'h00);
        return g;
    endfunction

    function automatic t_feed end_number(t_feed f, t_lex_state s);
        t_feed g;
        g = emit(f, s.flt ? KindFloat : KindInt, s.tbeg, s.vend - s.tbeg);
        g.st.mode = M_START;
        for (int i = 0; i < 2; i++) begin
            if (2'(i) < s.sufn) begin
                if (s.suf[8*i +: 8] == "-") begin
                    g.st.mode = M_MINUS;
                    g.st.tbeg = s.vend + 16'(i);
                end else begin
                    g = emit(g, KindErr, '0, '0);
                end
            end
        end
        g.st.suf  = '0;
        g.st.sufn = '0;
        g.relex   = 1'b1;
        return g;
    endfunction

    // One pass of the lexer over byte b in state s.
    function automatic t_feed lex_feed(t_lex_state s, logic [7:0] b, logic [15:0] pos);
        t_feed      f;
        logic [2:0] wlen;
        logic       hex;
        f         = '0;
        f.st      = s;
        wlen      = (s.mode == M_KW_F) ? 3'd4 : 3'd3;
        hex       = is_dig(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
        case (s.mode)
            M_START: begin
                case (b)
                    8'h00: begin
                        f         = emit(f, KindEof, '0, '0);
                        f.st      = LexReset;
                        f.clr_pos = 1'b1;
                    end
                    " ", 8'h0A, 8'h0D, 8'h09: ;
                    "%": f.st.mode = M_PCT;
                    "[": f = emit(f, KindArrL, '0, '0);
                    "]": f = emit(f, KindArrR, '0, '0);
                    "{": f = emit(f, KindObjL, '0, '0);
                    "}": f = emit(f, KindObjR, '0, '0);
                    ":": f = emit(f, KindColon, '0, '0);
                    ",": f = emit(f, KindComma, '0, '0);
                    "n": begin f.st.mode = M_KW_N; f.st.kw = '0; end
                    "t": begin f.st.mode = M_KW_T; f.st.kw = '0; end
                    "f": begin f.st.mode = M_KW_F; f.st.kw = '0; end
                    "-": begin f.st.mode = M_MINUS; f.st.tbeg = pos; end
                    "\"": begin f.st.mode = M_STR; f.st.tbeg = pos; end
                    default: begin
                        if (is_dig(b)) begin
                            f.st.tbeg = pos;
                            f.st.mode = (b == "0") ? M_ZERO : M_INTD;
                            f.st.vend = pos + 16'd1;
                            f.st.flt  = 1'b0;
                        end else begin
                            f = fail(f, b);
                        end
                    end
                endcase
            end
            M_PCT: begin
                f.st.mode = M_START;
                case (b)
                    "d":     f = emit(f, KindFmtD, '0, '0);
                    "f":     f = emit(f, KindFmtF, '0, '0);
                    "b":     f = emit(f, KindFmtB, '0, '0);
                    "s":     f = emit(f, KindFmtS, '0, '0);
                    "j":     f = emit(f, KindFmtJ, '0, '0);
                    default: f = fail(f, b);
                endcase
            end
            M_KW_N, M_KW_T, M_KW_F: begin
                if (s.kw >= wlen || b != kw_char(s.mode, s.kw)) begin
                    f = fail(f, b);
                end else if (s.kw + 3'd1 == wlen) begin
                    f = emit(f, (s.mode == M_KW_N) ? KindNull :
                                ((s.mode == M_KW_T) ? KindTrue : KindFalse), '0, '0);
                    f.st.mode = M_START;
                    f.st.kw   = '0;
                end else begin
                    f.st.kw = s.kw + 3'd1;
                end
            end
            M_MINUS: begin
                if (is_dig(b)) begin
                    f.st.mode = (b == "0") ? M_ZERO : M_INTD;
                    f.st.vend = pos + 16'd1;
                    f.st.flt  = 1'b0;
                end else begin
                    f = fail(f, b);
                end
            end
            M_ZERO, M_INTD, M_FRACD: begin
                if (is_dig(b) && s.mode != M_ZERO) begin
                    f.st.vend = pos + 16'd1;
                end else if (b == "." && s.mode != M_FRACD) begin
                    f.st.mode = M_DOT;
                    f.st.suf  = {8'h00, b};
                    f.st.sufn = 2'd1;
                end else if (b == "e" || b == "E") begin
                    f.st.mode = M_EXPE;
                    f.st.suf  = {8'h00, b};
                    f.st.sufn = 2'd1;
                end else begin
                    f = end_number(f, s);
                end
            end
            M_DOT, M_EXPE, M_EXPS, M_EXPD: begin
                if (is_dig(b)) begin
                    f.st.mode = (s.mode == M_DOT) ? M_FRACD : M_EXPD;
                    f.st.flt  = 1'b1;
                    f.st.vend = pos + 16'd1;
                    f.st.suf  = '0;
                    f.st.sufn = '0;
                end else if (s.mode == M_EXPE && (b == "+" || b == "-")) begin
                    f.st.mode = M_EXPS;
                    f.st.suf  = {b, s.suf[7:0]};
                    f.st.sufn = 2'd2;
                end else begin
                    f = end_number(f, s);
                end
            end
            M_STR: begin
                if (b == "\"") begin
                    f = emit(f, KindStr, s.tbeg, pos + 16'd1 - s.tbeg);
                    f.st.mode = M_START;
                end else if (b < 8'h20) begin
                    f = fail(f, b);
                end else if (b == "\\") begin
                    f.st.mode = M_ESC;
                end
            end
            M_ESC: begin
                case (b)
                    "/", "b", "f", "\\", "n", "r", "t", "\"": f.st.mode = M_STR;
                    "u": begin f.st.mode = M_HEX; f.st.kw = '0; end
                    default: f = fail(f, b);
                endcase
            end
            default: begin
                if (!hex) begin
                    f = fail(f, b);
                end else if (s.kw + 3'd1 >= 3'd4) begin
                    f.st.mode = M_STR;
                    f.st.kw   = '0;
                end else begin
                    f.st.kw = s.kw + 3'd1;
                end
            end
        endcase
        return f;
    endfunction

endpackage

[hw/rtl/jtl_core.sv]
// Lexer state registers and the per-byte next-state / token logic.
// Depends on jtl_pkg.
module jtl_core #(
    parameter int unsigned MAX_TEXT_LEN = jtl_pkg::MaxTextLenDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_byte,
    output jtl_pkg::t_batch o_batch
);
    import jtl_pkg::*;

    localparam logic [15:0] PosLimit =
        (MAX_TEXT_LEN < 32'd65535) ? 16'(MAX_TEXT_LEN) : 16'hFFFF;

    t_lex_state  r_st, n_st;
    logic [15:0] r_pos, n_pos;
    t_feed       f1, f2, f3;
    logic        clr;

    // at most three passes: number close, minus replay, end marker
    always_comb begin
        f1 = lex_feed(r_st, i_byte, r_pos);
        f2 = lex_feed(f1.st, i_byte, r_pos);
        f3 = lex_feed(f2.st, i_byte, r_pos);
        n_st = f1.st;
        clr  = f1.clr_pos;
        if (f1.relex) begin
            n_st = f2.st;
            clr  = f2.clr_pos;
            if (f2.relex) begin
                n_st = f3.st;
                clr  = f3.clr_pos;
            end
        end
        if (clr) begin
            n_pos = '0;
        end else if (i_byte != 8'h00 && r_pos < PosLimit) begin
            n_pos = r_pos + 16'd1;
        end else begin
            n_pos = r_pos;
        end
    end

    always_comb begin
        o_batch = '0;
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < f1.n && o_batch.cnt < 3'd4) begin
                o_batch.tok[o_batch.cnt[1:0]] = f1.tok[k];
                o_batch.cnt = o_batch.cnt + 3'd1;
            end
        end
        for (int k = 0; k < 3; k++) begin
            if (f1.relex && 2'(k) < f2.n && o_batch.cnt < 3'd4) begin
                o_batch.tok[o_batch.cnt[1:0]] = f2.tok[k];
                o_batch.cnt = o_batch.cnt + 3'd1;
            end
        end
        for (int k = 0; k < 3; k++) begin
            if (f1.relex && f2.relex && 2'(k) < f3.n && o_batch.cnt < 3'd4) begin
                o_batch.tok[o_batch.cnt[1:0]] = f3.tok[k];
                o_batch.cnt = o_batch.cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= LexReset;
            r_pos <= '0;
        end else if (i_take) begin
            r_st  <= n_st;
            r_pos <= n_pos;
        end
    end

endmodule

[hw/rtl/jtl_token_buf.sv]
// Result register: holds the tokens of one byte and hands them out one per transfer.
// Depends on jtl_pkg.
module jtl_token_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  jtl_pkg::t_batch i_batch,
    input  logic            i_ready,
    output logic            o_valid,
    output logic            o_last,
    output jtl_pkg::t_token o_tok,
    output logic            o_free
);
    import jtl_pkg::*;

    t_token [3:0] r_tok;
    logic [2:0]   r_left;
    logic [1:0]   r_rd;

    assign o_valid = (r_left != 3'd0);
    assign o_last  = (r_left == 3'd1);
    assign o_tok   = r_tok[r_rd];
    assign o_free  = (r_left == 3'd0) || (o_last && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_rd   <= '0;
        end else if (i_load) begin
            r_left <= i_batch.cnt;
            r_rd   <= '0;
        end else if (o_valid && i_ready) begin
            r_left <= r_left - 3'd1;
            r_rd   <= r_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tok <= i_batch.tok;
        end
    end

endmodule

[hw/rtl/json_token_lexer.sv]
// JSON token lexer: takes one text byte per cycle while the result register is free, and a
// byte's tokens sit in the result register from the cycle after its transfer. A byte that
// yields tokens (up to four: a closed number, dangling suffix errors, end of text) holds
// off the next byte until its last token leaves, so also while the receiver stalls; a byte
// with no token never stalls the input. Tokens leave in order, tlast on the last token of
// each byte. Depends on jtl_pkg.
module json_token_lexer #(
    parameter int unsigned MAX_TEXT_LEN = jtl_pkg::MaxTextLenDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [4:0] token_kind, [20:5] token_offset,
                                     // [36:21] token_length, [39:37] zero
    output logic        o_m_tlast    // run_last
);
    import jtl_pkg::*;

    t_batch batch;
    t_token tok;
    logic   take;

    assign take = i_s_tvalid && o_s_tready;

    jtl_core #(.MAX_TEXT_LEN(MAX_TEXT_LEN)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_s_tdata),
        .o_batch (batch)
    );

    jtl_token_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take),
        .i_batch (batch),
        .i_ready (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_last  (o_m_tlast),
        .o_tok   (tok),
        .o_free  (o_s_tready)
    );

    assign o_m_tdata = {3'b000, tok.len, tok.off, tok.kind};

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> (!o_m_tvalid || (o_m_tlast && i_m_tready)))
        else $error("byte taken over undelivered tokens");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[4:0] <= KindFmtJ))
        else $error("token kind out of range");

    a_zero_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[4:0] != KindInt && o_m_tdata[4:0] != KindFloat
         && o_m_tdata[4:0] != KindStr) |-> (o_m_tdata[36:5] == 32'd0))
        else $error("offset or length on a token without a span");

endmodule
